// File: sv/pcfs_pkg.sv
// Package for the per-cpu class free stack unit: word types, status and
// register codes, default parameter values. No dependencies.
package pcfs_pkg;

  localparam int FUNC_W     = 1;
  localparam int CPU_W      = 10;
  localparam int CLASS_W    = 8;
  localparam int HANDLE_W   = 32;
  localparam int LIMIT_W    = 7;
  localparam int STATUS_W   = 3;
  localparam int WIN_W      = 5;
  localparam int CAP_W      = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam int DEF_NUM_CPUS    = 8;
  localparam int DEF_NUM_CLASSES = 32;
  localparam int DEF_STACK_DEPTH = 64;
  localparam int DEF_HANDLE_BITS = 32;

  localparam int MAX_BATCH = 64;

  localparam logic [FUNC_W-1:0] FUNC_PUSH = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_POP  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK            = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NULL          = 3'd1;
  localparam logic [STATUS_W-1:0] ST_CLASS_INVALID = 3'd2;
  localparam logic [STATUS_W-1:0] ST_OUTSIDE       = 3'd3;
  localparam logic [STATUS_W-1:0] ST_CPU_FAIL      = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FULL          = 3'd5;
  localparam logic [STATUS_W-1:0] ST_EMPTY         = 3'd6;
  localparam logic [STATUS_W-1:0] ST_ZERO          = 3'd7;

  localparam logic [CFG_IDX_W-1:0] REG_WIN_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 2'd2;

  localparam logic [WIN_W-1:0] RST_WIN_LOW  = 5'd0;
  localparam logic [WIN_W-1:0] RST_WIN_HIGH = 5'd31;
  localparam logic [CAP_W-1:0] RST_CAPACITY = 7'd64;

  typedef struct packed {
    logic [FUNC_W-1:0]   func;
    logic                cpu_valid;
    logic [CPU_W-1:0]    cpu_id;
    logic [CLASS_W-1:0]  size_class;
    logic [HANDLE_W-1:0] handle_in;
    logic [LIMIT_W-1:0]  batch_limit;
  } in_word_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] handle_out;
    logic                last;
  } out_word_t;

endpackage

// File: sv/pcfs_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module pcfs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/per_cpu_class_free_stack_unit.sv
// Top level of the per-cpu class free stack unit: request sequencer, config
// registers and output register. Depends on pcfs_pkg and pcfs_ram.
//
// One LIFO of handles per (cpu, size class) pair; a push stacks one handle, a
// pop returns up to batch_limit handles newest first, last marked on the final
// word. Requests are handled one at a time. A request that fails a check is
// answered after the cpu-number reduction (two registered multiplies); a push
// or pop goes on through the stack index and address multiplies and the
// registered read of the fill-count memory, and a pop then returns one handle
// per cycle while out_ready is high. After reset the fill-count memory is
// cleared one entry a cycle, with in_ready low; config writes are taken as
// ever. Handles live in a second RAM of NUM_CPUS*NUM_CLASSES*STACK_DEPTH
// entries with no reset. Config must only be written while the unit is idle.
module per_cpu_class_free_stack_unit
  import pcfs_pkg::*;
#(
  parameter int NUM_CPUS    = DEF_NUM_CPUS,
  parameter int NUM_CLASSES = DEF_NUM_CLASSES,
  parameter int STACK_DEPTH = DEF_STACK_DEPTH,
  parameter int HANDLE_BITS = DEF_HANDLE_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_word_t              in_word,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_word_t             out_word,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int NUM_STACKS = NUM_CPUS * NUM_CLASSES;
  localparam int STORE_SIZE = NUM_STACKS * STACK_DEPTH;
  localparam int HW  = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;
  localparam int CPW = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
  localparam int SKW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam int SA  = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;
  localparam int FW  = $clog2(STACK_DEPTH + 1);
  localparam int CW  = (FW > LIMIT_W) ? FW : LIMIT_W;
  localparam int RSH = 20;
  localparam int RW  = RSH + 1;
  localparam int PW  = CPU_W + RW;
  localparam logic [RW-1:0] RECIP = RW'(((1 << RSH) + NUM_CPUS - 1) / NUM_CPUS);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_QUOT   = 4'd2;
  localparam logic [3:0] S_REM    = 4'd3;
  localparam logic [3:0] S_INDEX  = 4'd4;
  localparam logic [3:0] S_READ   = 4'd5;
  localparam logic [3:0] S_DECIDE = 4'd6;
  localparam logic [3:0] S_POP    = 4'd7;
  localparam logic [3:0] S_REPLY  = 4'd8;

  logic [3:0]          state, state_next;
  in_word_t            req;
  logic [CPU_W-1:0]    quot, quot_next;
  logic [STATUS_W-1:0] reply_status, reply_status_next;
  logic [CPW-1:0]      cpu_mod, cpu_mod_next;
  logic [SKW-1:0]      stack, stack_next;
  logic [SA-1:0]       base, base_next;
  logic [FW-1:0]       ptr, ptr_next;
  logic [CW-1:0]       cnt, cnt_next;
  logic [SKW-1:0]      clr_cnt, clr_cnt_next;
  logic [WIN_W-1:0]    win_low, win_high;
  logic [CAP_W-1:0]    capacity;

  logic                fill_we, fill_re;
  logic [SKW-1:0]      fill_waddr;
  logic [FW-1:0]       fill_wdata, fill_rd;
  logic                store_we, store_re;
  logic [SA-1:0]       store_waddr, store_raddr;
  logic [HW-1:0]       store_rd;

  logic                out_free, emit;
  out_word_t           emit_word;

  logic [PW-1:0]       prod;
  logic [15:0]         qn, rem16, stack16;
  logic [23:0]         base24;
  logic [HW-1:0]       hmask;
  logic [STATUS_W-1:0] chk;
  logic [LIMIT_W-1:0]  lim;
  logic [CW-1:0]       fill_c, cap, take;

  pcfs_ram #(.WIDTH(FW), .DEPTH(NUM_STACKS), .AW(SKW)) u_fill_ram (
    .clk   (clk),
    .we    (fill_we),
    .waddr (fill_waddr),
    .wdata (fill_wdata),
    .re    (fill_re),
    .raddr (stack),
    .rdata (fill_rd)
  );

  pcfs_ram #(.WIDTH(HW), .DEPTH(STORE_SIZE), .AW(SA)) u_store_ram (
    .clk   (clk),
    .we    (store_we),
    .waddr (store_waddr),
    .wdata (req.handle_in[HW-1:0]),
    .re    (store_re),
    .raddr (store_raddr),
    .rdata (store_rd)
  );

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  assign prod    = PW'(req.cpu_id) * PW'(RECIP);
  assign qn      = 16'(quot) * 16'(NUM_CPUS);
  assign rem16   = 16'(req.cpu_id) - qn;
  assign stack16 = 16'(cpu_mod) * 16'(NUM_CLASSES) + 16'(req.size_class);
  assign base24  = 24'(stack) * 24'(STACK_DEPTH);
  assign hmask   = req.handle_in[HW-1:0];

  assign lim    = (req.batch_limit > LIMIT_W'(MAX_BATCH)) ? LIMIT_W'(MAX_BATCH)
                                                          : req.batch_limit;
  assign fill_c = CW'(fill_rd);
  assign cap    = (CW'(capacity) < CW'(STACK_DEPTH)) ? CW'(capacity) : CW'(STACK_DEPTH);
  assign take   = (CW'(lim) < fill_c) ? CW'(lim) : fill_c;

  always_comb begin
    priority if (req.func == FUNC_PUSH && hmask == '0) begin
      chk = ST_NULL;
    end else if (req.func == FUNC_POP && req.batch_limit == '0) begin
      chk = ST_ZERO;
    end else if (req.size_class >= CLASS_W'(NUM_CLASSES)) begin
      chk = ST_CLASS_INVALID;
    end else if (req.size_class < CLASS_W'(win_low) ||
                 req.size_class > CLASS_W'(win_high)) begin
      chk = ST_OUTSIDE;
    end else if (!req.cpu_valid) begin
      chk = ST_CPU_FAIL;
    end else begin
      chk = ST_OK;
    end
  end

  always_comb begin
    state_next        = state;
    quot_next         = quot;
    reply_status_next = reply_status;
    cpu_mod_next      = cpu_mod;
    stack_next        = stack;
    base_next         = base;
    ptr_next          = ptr;
    cnt_next          = cnt;
    clr_cnt_next      = clr_cnt;
    fill_we           = 1'b0;
    fill_re           = 1'b0;
    fill_waddr        = stack;
    fill_wdata        = '0;
    store_we          = 1'b0;
    store_re          = 1'b0;
    store_waddr       = base + SA'(fill_rd);
    emit              = 1'b0;
    emit_word         = '0;
    unique case (state)
      S_CLEAR: begin
        fill_we    = 1'b1;
        fill_waddr = clr_cnt;
        if (clr_cnt == SKW'(NUM_STACKS - 1)) begin
          state_next = S_IDLE;
        end else begin
          clr_cnt_next = clr_cnt + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_QUOT;
        end
      end
      S_QUOT: begin
        quot_next         = prod[RSH+CPU_W-1:RSH];
        reply_status_next = chk;
        state_next        = S_REM;
      end
      S_REM: begin
        cpu_mod_next = CPW'(rem16);
        state_next   = (reply_status == ST_OK) ? S_INDEX : S_REPLY;
      end
      S_INDEX: begin
        stack_next = SKW'(stack16);
        state_next = S_READ;
      end
      S_READ: begin
        fill_re    = 1'b1;
        base_next  = SA'(base24);
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (req.func == FUNC_PUSH) begin
          if (fill_c >= cap) begin
            reply_status_next = ST_FULL;
            state_next        = S_REPLY;
          end else if (out_free) begin
            store_we   = 1'b1;
            fill_we    = 1'b1;
            fill_wdata = fill_rd + 1'b1;
            emit       = 1'b1;
            emit_word  = '{status: ST_OK, handle_out: '0, last: 1'b1};
            state_next = S_IDLE;
          end
        end else begin
          if (fill_rd == '0) begin
            reply_status_next = ST_EMPTY;
            state_next        = S_REPLY;
          end else begin
            fill_we    = 1'b1;
            fill_wdata = FW'(fill_c - take);
            cnt_next   = take;
            ptr_next   = fill_rd - 1'b1;
            store_re   = 1'b1;
            state_next = S_POP;
          end
        end
      end
      S_POP: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_word = '{status: ST_OK, handle_out: HANDLE_W'(store_rd),
                        last: (cnt == CW'(1))};
          cnt_next  = cnt - 1'b1;
          if (cnt == CW'(1)) begin
            state_next = S_IDLE;
          end else begin
            ptr_next = ptr - 1'b1;
            store_re = 1'b1;
          end
        end
      end
      S_REPLY: begin
        if (out_free) begin
          emit       = 1'b1;
          emit_word  = '{status: reply_status, handle_out: '0, last: 1'b1};
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    store_raddr = base + SA'(ptr_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
    end else begin
      state   <= state_next;
      clr_cnt <= clr_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req <= in_word;
    end
    quot         <= quot_next;
    reply_status <= reply_status_next;
    cpu_mod      <= cpu_mod_next;
    stack        <= stack_next;
    base         <= base_next;
    ptr          <= ptr_next;
    cnt          <= cnt_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_low  <= RST_WIN_LOW;
      win_high <= RST_WIN_HIGH;
      capacity <= RST_CAPACITY;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WIN_LOW:  win_low  <= cfg_data[WIN_W-1:0];
        REG_WIN_HIGH: win_high <= cfg_data[WIN_W-1:0];
        REG_CAPACITY: capacity <= cfg_data[CAP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_word <= emit_word;
    end
  end

endmodule
